### src/cre_pkg.sv
package cre_pkg;

    // character constants
    localparam logic [7:0] DASH_CHAR  = 8'h2D;
    localparam logic [7:0] UPPER_LO   = 8'h41;
    localparam logic [7:0] UPPER_HI   = 8'h5A;
    localparam logic [7:0] LOWER_LO   = 8'h61;
    localparam logic [7:0] LOWER_HI   = 8'h7A;
    localparam logic [7:0] DIGIT_LO   = 8'h30;
    localparam logic [7:0] DIGIT_HI   = 8'h39;

    // default depth of the command queue between front and back
    localparam int CRE_QUEUE_DEPTH = 2;

    // character class of a byte
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_UPPER = 2'd1,
        CLS_LOWER = 2'd2,
        CLS_DIGIT = 2'd3
    } t_cls;

    // what the back end writes for one input transaction
    typedef enum logic [2:0] {
        K_ONE   = 3'd0,   // the new byte
        K_A     = 3'd1,   // the held start byte only
        K_AC    = 3'd2,   // held start byte, then the new byte
        K_AD    = 3'd3,   // held start byte, then dash
        K_LIT3  = 3'd4,   // held start byte, dash, new byte
        K_RANGE = 3'd5    // every code from start to new byte
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  a;
        logic [7:0]  c;
        logic        last;
    } t_cmd;

    function automatic t_cls char_class(input logic [7:0] ch);
        t_cls cls;
        cls = CLS_NONE;
        if (ch inside {[UPPER_LO:UPPER_HI]}) begin
            cls = CLS_UPPER;
        end else if (ch inside {[LOWER_LO:LOWER_HI]}) begin
            cls = CLS_LOWER;
        end else if (ch inside {[DIGIT_LO:DIGIT_HI]}) begin
            cls = CLS_DIGIT;
        end
        return cls;
    endfunction

endpackage

### src/cre_in_if.sv
interface cre_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

### src/cre_out_if.sv
interface cre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_end;
    logic       string_end;

    modport source (output valid, output out_char, output run_end, output string_end,
                    input ready);
    modport sink   (input valid, input out_char, input run_end, input string_end,
                    output ready);
endinterface

### src/cre_front.sv
module cre_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cre_in_if.sink          i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output cre_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_START = 3'b010,
        PH_DASH  = 3'b100
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [7:0]      r_held, n_held;
    logic            accept;
    cre_pkg::t_cls   cls_c;
    logic            range_ok;

    // accept whenever the queue has room
    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    assign cls_c    = cre_pkg::char_class(i_in.in_char);
    assign range_ok = (cre_pkg::char_class(r_held) != cre_pkg::CLS_NONE)
                   && (cls_c == cre_pkg::char_class(r_held))
                   && (i_in.in_char > r_held);

    // classify the byte against what is held
    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        o_push     = 1'b0;
        o_cmd.kind = cre_pkg::K_ONE;
        o_cmd.a    = r_held;
        o_cmd.c    = i_in.in_char;
        o_cmd.last = i_in.in_last;
        if (accept) begin
            case (r_phase)
                PH_START: begin
                    if (i_in.in_char == cre_pkg::DASH_CHAR) begin
                        if (i_in.in_last) begin
                            o_push     = 1'b1;
                            o_cmd.kind = cre_pkg::K_AD;
                            n_phase    = PH_IDLE;
                        end else begin
                            n_phase    = PH_DASH;
                        end
                    end else if (cls_c != cre_pkg::CLS_NONE && !i_in.in_last) begin
                        o_push     = 1'b1;
                        o_cmd.kind = cre_pkg::K_A;
                        n_held     = i_in.in_char;
                        n_phase    = PH_START;
                    end else begin
                        o_push     = 1'b1;
                        o_cmd.kind = cre_pkg::K_AC;
                        n_phase    = PH_IDLE;
                    end
                end
                PH_DASH: begin
                    o_push     = 1'b1;
                    o_cmd.kind = range_ok ? cre_pkg::K_RANGE : cre_pkg::K_LIT3;
                    n_phase    = PH_IDLE;
                end
                default: begin
                    if (cls_c != cre_pkg::CLS_NONE && !i_in.in_last) begin
                        n_held  = i_in.in_char;
                        n_phase = PH_START;
                    end else begin
                        o_push  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
            endcase
        end
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

`ifndef SYNTH
    // a held byte is always alphanumeric
    a_held_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (cre_pkg::char_class(r_held) != cre_pkg::CLS_NONE))
        else $error("front holds a non-alphanumeric byte");
`endif

endmodule

### src/cre_queue.sv
module cre_queue #(
    parameter int DEPTH = cre_pkg::CRE_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cre_pkg::t_cmd   i_data,
    input  logic            i_pop,
    output cre_pkg::t_cmd   o_head,
    output logic            o_empty,
    output logic            o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cre_pkg::t_cmd       r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr, r_rd;
    logic [CNT_W-1:0]    r_count;
    logic                do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    // front never offers a command to a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

### src/cre_back.sv
module cre_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cre_pkg::t_cmd   i_head,
    input  logic            i_empty,
    output logic            o_pop,
    cre_out_if.source       o_out
);

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_RUN  = 2'b10
    } t_bstate;

    t_bstate          r_state, n_state;
    cre_pkg::t_cmd    r_cmd;
    logic [7:0]       r_ch;
    logic [1:0]       r_pos;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_run_end;
    logic             r_out_string_end;
    logic             can_load;
    logic             fire;
    logic             load;
    logic [7:0]       cur_byte;
    logic             cur_final;

    assign can_load = !r_out_valid || o_out.ready;
    assign fire     = (r_state == BK_RUN) && can_load;

    // byte at the current position of the command
    always_comb begin
        cur_byte  = r_cmd.c;
        cur_final = 1'b1;
        case (r_cmd.kind)
            cre_pkg::K_ONE: begin
                cur_byte  = r_cmd.c;
                cur_final = 1'b1;
            end
            cre_pkg::K_A: begin
                cur_byte  = r_cmd.a;
                cur_final = 1'b1;
            end
            cre_pkg::K_AC: begin
                cur_byte  = (r_pos == 2'd0) ? r_cmd.a : r_cmd.c;
                cur_final = (r_pos != 2'd0);
            end
            cre_pkg::K_AD: begin
                cur_byte  = (r_pos == 2'd0) ? r_cmd.a : cre_pkg::DASH_CHAR;
                cur_final = (r_pos != 2'd0);
            end
            cre_pkg::K_LIT3: begin
                cur_byte  = (r_pos == 2'd0) ? r_cmd.a :
                            (r_pos == 2'd1) ? cre_pkg::DASH_CHAR : r_cmd.c;
                cur_final = (r_pos == 2'd2);
            end
            cre_pkg::K_RANGE: begin
                cur_byte  = r_ch;
                cur_final = (r_ch == r_cmd.c);
            end
            default: begin
                cur_byte  = r_cmd.c;
                cur_final = 1'b1;
            end
        endcase
    end

    // sequencer: take the next command at idle or right after a final byte
    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    load    = 1'b1;
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (fire && cur_final) begin
                    load    = !i_empty;
                    n_state = i_empty ? BK_IDLE : BK_RUN;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command and position registers
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_head;
            r_ch  <= i_head.a;
            r_pos <= 2'd0;
        end else if (fire) begin
            r_ch  <= r_ch + 8'd1;
            r_pos <= r_pos + 2'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_char       <= cur_byte;
            r_out_run_end    <= cur_final;
            r_out_string_end <= cur_final && r_cmd.last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_char   = r_out_char;
    assign o_out.run_end    = r_out_run_end;
    assign o_out.string_end = r_out_string_end;

`ifndef SYNTH
    // a range run never steps past its end byte
    a_range_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_RUN && r_cmd.kind == cre_pkg::K_RANGE) |-> (r_ch <= r_cmd.c))
        else $error("range run past its end");
    // end of string only on the last byte of a transaction's run
    a_string_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_string_end) |-> r_out_run_end)
        else $error("string end without run end");
    // no command taken while the current one still has bytes to write
    a_pop_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_state == BK_RUN) |-> (fire && cur_final))
        else $error("command popped mid run");
`endif

endmodule

### src/char_range_expander.sv
// Character range expander. Bytes of a string come in on i_in, one per
// transaction, with in_last on the final byte; the expanded string leaves on
// o_out with run_end on the last byte caused by each input byte and string_end
// on the final byte of the string. A front stage takes one input byte per cycle
// while its command queue (QUEUE_DEPTH entries) has room, tracks the held start
// byte and dash, and queues one command per input byte that yields output. A
// back stage writes one output byte per cycle into a registered output while
// the receiver is ready; an input byte yields one output byte if plain, two
// or three for a flushed literal and up to 26 for a range such as a-z. The
// input stalls only when the queue is full behind a long run; a byte that is
// only held yields no output. With an empty queue the first output byte goes
// through the queue entry, the back command register and the output register.
module char_range_expander #(
    parameter int QUEUE_DEPTH = cre_pkg::CRE_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cre_in_if.sink      i_in,
    cre_out_if.source   o_out
);

    logic            q_push;
    logic            q_pop;
    logic            q_empty;
    logic            q_full;
    cre_pkg::t_cmd   q_wr_cmd;
    cre_pkg::t_cmd   q_head;

    // classify input and track held bytes
    cre_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_wr_cmd)
    );

    // command queue between front and back
    cre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // expand commands into output bytes
    cre_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // hold state of the expected-behavior tracker
    typedef enum logic [1:0] {
        HOLD_NONE  = 2'd0,
        HOLD_START = 2'd1,
        HOLD_DASH  = 2'd2
    } t_hold;

    // one byte of the expanded string
    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       string_end;
    } t_outbyte;

    // one row of the directed table
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic [7:0] want;
        logic       want_end;
    } t_row;

    localparam int RANDOM_ITEMS = 205;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 24;

    logic i_clk;
    logic i_rst_n;

    cre_in_if  in_bus ();
    cre_out_if out_bus ();

    char_range_expander dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // tracker state
    t_hold      hold_state;
    logic [7:0] held_byte;
    t_outbyte   step_bytes[$];
    t_outbyte   pending_out[$];

    t_row       plan[$];
    logic [7:0] text_q[$];

    int  errors;
    int  items_sent;
    int  bytes_checked;
    int  ranges_seen;
    int  strings_seen;
    bit  calm;
    bit  hold_request;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #2_000_000;
        $display("FAIL char_range_expander");
        $finish;
    end

    function automatic cre_pkg::t_cls byte_class(input logic [7:0] c);
        if (c >= cre_pkg::UPPER_LO && c <= cre_pkg::UPPER_HI) return cre_pkg::CLS_UPPER;
        if (c >= cre_pkg::LOWER_LO && c <= cre_pkg::LOWER_HI) return cre_pkg::CLS_LOWER;
        if (c >= cre_pkg::DIGIT_LO && c <= cre_pkg::DIGIT_HI) return cre_pkg::CLS_DIGIT;
        return cre_pkg::CLS_NONE;
    endfunction

    function automatic void emit_byte(input logic [7:0] c);
        t_outbyte b;
        b.ch = c;
        b.run_end = 1'b0;
        b.string_end = 1'b0;
        step_bytes.push_back(b);
    endfunction

    // a byte seen with nothing held
    function automatic void take_fresh(input logic [7:0] c, input logic last);
        if (byte_class(c) != cre_pkg::CLS_NONE && !last) begin
            held_byte = c;
            hold_state = HOLD_START;
        end else begin
            hold_state = HOLD_NONE;
            emit_byte(c);
        end
    endfunction

    // work out the output bytes caused by one input transaction
    function automatic void expand_step(input logic [7:0] c, input logic last);
        cre_pkg::t_cls k;
        step_bytes.delete();
        case (hold_state)
            HOLD_START: begin
                if (c == cre_pkg::DASH_CHAR) begin
                    if (last) begin
                        emit_byte(held_byte);
                        emit_byte(cre_pkg::DASH_CHAR);
                        hold_state = HOLD_NONE;
                    end else begin
                        hold_state = HOLD_DASH;
                    end
                end else begin
                    emit_byte(held_byte);
                    take_fresh(c, last);
                end
            end
            HOLD_DASH: begin
                k = byte_class(held_byte);
                if (k != cre_pkg::CLS_NONE && byte_class(c) == k && c > held_byte) begin
                    for (int x = held_byte; x <= c; x++) emit_byte(x[7:0]);
                    ranges_seen++;
                end else begin
                    emit_byte(held_byte);
                    emit_byte(cre_pkg::DASH_CHAR);
                    emit_byte(c);
                end
                hold_state = HOLD_NONE;
            end
            default: take_fresh(c, last);
        endcase
        if (step_bytes.size() > 0) begin
            step_bytes[step_bytes.size() - 1].run_end = 1'b1;
            step_bytes[step_bytes.size() - 1].string_end = last;
        end
        if (last) strings_seen++;
    endfunction

    function automatic void add_row(input logic [7:0] ch, input logic last,
                                    input logic typed, input logic [7:0] want,
                                    input logic want_end);
        t_row r;
        r = '{ch, last, typed, want, want_end};
        plan.push_back(r);
    endfunction

    function automatic logic [7:0] rand_alnum();
        case ($urandom_range(2))
            0: return cre_pkg::UPPER_LO + 8'($urandom_range(25));
            1: return cre_pkg::LOWER_LO + 8'($urandom_range(25));
            default: return cre_pkg::DIGIT_LO + 8'($urandom_range(9));
        endcase
    endfunction

    // queue up the next random fragment of text
    function automatic void fill_text();
        int          r;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  a;
        logic [7:0]  c;
        r = $urandom_range(99);
        case ($urandom_range(2))
            0: begin lo = cre_pkg::UPPER_LO; hi = cre_pkg::UPPER_HI; end
            1: begin lo = cre_pkg::LOWER_LO; hi = cre_pkg::LOWER_HI; end
            default: begin lo = cre_pkg::DIGIT_LO; hi = cre_pkg::DIGIT_HI; end
        endcase
        if (r < 55) begin
            // well-formed range, sometimes the full class
            if ($urandom_range(7) == 0) begin
                a = lo;
                c = hi;
            end else begin
                a = lo + 8'($urandom_range(hi - lo - 8'd1));
                c = a + 8'd1 + 8'($urandom_range(hi - a - 8'd1));
            end
            text_q.push_back(a);
            text_q.push_back(cre_pkg::DASH_CHAR);
            text_q.push_back(c);
        end else if (r < 70) begin
            // broken range with any end byte
            text_q.push_back(rand_alnum());
            text_q.push_back(cre_pkg::DASH_CHAR);
            text_q.push_back(8'($urandom_range(255)));
        end else if (r < 85) begin
            text_q.push_back(8'($urandom_range(255)));
        end else if (r < 93) begin
            text_q.push_back(cre_pkg::DASH_CHAR);
        end else begin
            text_q.push_back(rand_alnum());
        end
    endfunction

    // offer one byte and record what it should produce once accepted
    task automatic send_byte(input logic [7:0] c, input logic last, input logic typed,
                             input logic [7:0] want, input logic want_end);
        t_outbyte b;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.in_char <= c;
        in_bus.in_last <= last;
        do @(posedge i_clk); while (!in_bus.ready);
        expand_step(c, last);
        if (typed) begin
            b = '{want, 1'b1, want_end};
            pending_out.push_back(b);
        end else begin
            foreach (step_bytes[i]) pending_out.push_back(step_bytes[i]);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    // receiver: random backpressure, one long hold-off
    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done && hold_left == 0) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                out_bus.ready <= 1'b0;
                hold_left--;
                if (hold_left == 0) hold_done = 1'b1;
            end else begin
                out_bus.ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // compare each output transaction with the oldest expected byte
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin : check_out
            t_outbyte w;
            if (pending_out.size() == 0) begin
                $display("%0t: unexpected byte %h run_end %b string_end %b", $time,
                         out_bus.out_char, out_bus.run_end, out_bus.string_end);
                errors++;
            end else begin
                w = pending_out.pop_front();
                if (out_bus.out_char !== w.ch) begin
                    $display("%0t: out_char expected %h actual %h", $time,
                             w.ch, out_bus.out_char);
                    errors++;
                end
                if (out_bus.run_end !== w.run_end) begin
                    $display("%0t: run_end expected %b actual %b (char %h)", $time,
                             w.run_end, out_bus.run_end, w.ch);
                    errors++;
                end
                if (out_bus.string_end !== w.string_end) begin
                    $display("%0t: string_end expected %b actual %b (char %h)", $time,
                             w.string_end, out_bus.string_end, w.ch);
                    errors++;
                end
            end
            bytes_checked++;
        end
    end

    // stimulus
    initial begin : stimulus
        logic [7:0] c;
        logic       last;
        int         n;
        errors = 0;
        items_sent = 0;
        bytes_checked = 0;
        ranges_seen = 0;
        strings_seen = 0;
        calm = 1'b0;
        hold_request = 1'b0;
        hold_state = HOLD_NONE;
        held_byte = 8'h00;
        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.in_char = 8'h00;
        in_bus.in_last = 1'b0;

        // directed table
        add_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0);        // zero byte
        add_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0);
        add_row(cre_pkg::DASH_CHAR, 1'b0, 1'b1, cre_pkg::DASH_CHAR, 1'b0); // leading dash
        add_row("a", 1'b0, 1'b0, 8'h00, 1'b0);            // full lower range
        add_row(cre_pkg::DASH_CHAR, 1'b0, 1'b0, 8'h00, 1'b0);
        add_row("z", 1'b0, 1'b0, 8'h00, 1'b0);
        add_row("9", 1'b0, 1'b0, 8'h00, 1'b0);            // descending, literal
        add_row(cre_pkg::DASH_CHAR, 1'b0, 1'b0, 8'h00, 1'b0);
        add_row("0", 1'b0, 1'b0, 8'h00, 1'b0);
        add_row("k", 1'b0, 1'b0, 8'h00, 1'b0);            // held byte then new start
        add_row("Q", 1'b0, 1'b0, 8'h00, 1'b0);
        add_row(cre_pkg::DASH_CHAR, 1'b0, 1'b0, 8'h00, 1'b0);
        add_row("R", 1'b0, 1'b0, 8'h00, 1'b0);            // two-byte range
        add_row("A", 1'b0, 1'b0, 8'h00, 1'b0);            // dash at string end
        add_row(cre_pkg::DASH_CHAR, 1'b1, 1'b0, 8'h00, 1'b0);
        add_row("x", 1'b1, 1'b1, "x", 1'b1);              // alnum last byte not held
        add_row("0", 1'b0, 1'b0, 8'h00, 1'b0);            // digit range ends string
        add_row(cre_pkg::DASH_CHAR, 1'b0, 1'b0, 8'h00, 1'b0);
        add_row("9", 1'b1, 1'b0, 8'h00, 1'b0);
        add_row("b", 1'b0, 1'b0, 8'h00, 1'b0);            // double dash, literal
        add_row(cre_pkg::DASH_CHAR, 1'b0, 1'b0, 8'h00, 1'b0);
        add_row(cre_pkg::DASH_CHAR, 1'b0, 1'b0, 8'h00, 1'b0);
        add_row(cre_pkg::DASH_CHAR, 1'b1, 1'b1, cre_pkg::DASH_CHAR, 1'b1); // stray dash
        add_row("Z", 1'b0, 1'b0, 8'h00, 1'b0);
        add_row(8'h80, 1'b1, 1'b0, 8'h00, 1'b0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            send_byte(plan[i].ch, plan[i].last, plan[i].typed, plan[i].want,
                      plan[i].want_end);
        end

        // random text, mostly well-formed ranges
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 40) hold_request = 1'b1;
            calm = (n >= 120 && n < 180);
            if (text_q.size() == 0) fill_text();
            c = text_q.pop_front();
            last = ($urandom_range(9) == 0);
            send_byte(c, last, 1'b0, 8'h00, 1'b0);
        end
        in_bus.valid <= 1'b0;
        calm = 1'b0;

        // drain and let any stray output show up
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("sent %0d input bytes in %0d strings, checked %0d output bytes",
                 items_sent, strings_seen, bytes_checked);
        $display("expanded %0d ranges, with one long output hold-off", ranges_seen);
        if (errors == 0) begin
            $display("PASS char_range_expander");
        end else begin
            $display("FAIL char_range_expander");
        end
        $finish;
    end

endmodule
